// File: sv/owdm_pkg.sv
// ----------------------------------------------------------------------------
// Omni wheel drive mixer package
// Shared widths, register indexes and the wheel projection coefficients.
// ----------------------------------------------------------------------------
package owdm_pkg;

    // Field and datapath widths.
    localparam int IN_W        = 16;   // Q7.8 command fields
    localparam int SQ_W        = 31;   // square of a 16-bit signed value
    localparam int RAD_W       = 32;   // sum of two squares
    localparam int ROOT_W      = 16;   // integer square root
    localparam int REM_W       = 20;   // root remainder
    localparam int ROOT_STAGES = 4;    // pipeline stages of the root
    localparam int ROOT_STEPS  = 4;    // root digits resolved per stage
    localparam int SECT_W      = 3;    // sector index 0..6, 3 means zero angle
    localparam int COEF_W      = 24;   // signed projection coefficient times 40
    localparam int COEF_MAG_W  = 23;
    localparam int PROD_W      = ROOT_W + COEF_MAG_W;
    localparam int PROJ_SHIFT  = 25;   // Q0.32 coefficient over 2^15, then 2^40
    localparam int PROJ_W      = PROD_W - PROJ_SHIFT;
    localparam int SUM_W       = 24;   // projection times 256 plus turn term
    localparam int DUTY_W      = 16;
    localparam int OFFSET_W    = 12;
    localparam int WHEELS      = 3;
    localparam int WHEEL_W     = 2;

    // Configuration port.
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_BREAKAWAY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT = 1'd1;
    localparam logic [OFFSET_W-1:0]  BREAKAWAY_RST  = 12'd750;
    localparam logic [DUTY_W-1:0]    DUTY_LIMIT_RST = 16'd3000;

    // Sector index of the zero angle; sectors run from -3 to 3 around it.
    localparam logic [SECT_W-1:0] SECT_ZERO = 3'd3;

    // Wheel 2 takes the turn term negated; wheels 2 and 3 are mounted inverted.
    localparam logic [WHEELS-1:0] TURN_NEG_MASK = 3'b010;
    localparam logic [WHEELS-1:0] INVERT_MASK   = 3'b110;

    // Coefficient magnitudes: (cos * wx + sin * wy) / 2^15, times the wheel gain 40.
    localparam logic signed [COEF_W-1:0] COEF_A = 24'sd4540320;
    localparam logic signed [COEF_W-1:0] COEF_B = 24'sd4540400;
    localparam logic signed [COEF_W-1:0] COEF_C = 24'sd80;
    localparam logic signed [COEF_W-1:0] COEF_D = 24'sd4540480;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } root_state_t;

    function automatic logic signed [COEF_W-1:0] coef_of(
        input logic [SECT_W-1:0]  sect,
        input logic [WHEEL_W-1:0] wheel
    );
        logic signed [COEF_W-1:0] c1;
        logic signed [COEF_W-1:0] c2;
        logic signed [COEF_W-1:0] c3;
        logic signed [COEF_W-1:0] sel;
        case (sect)
            3'd0:    begin c1 =  COEF_A; c2 =  COEF_A; c3 = '0;      end
            3'd1:    begin c1 =  COEF_B; c2 = -COEF_C; c3 = -COEF_D; end
            3'd2:    begin c1 =  COEF_C; c2 = -COEF_B; c3 = -COEF_D; end
            3'd3:    begin c1 = -COEF_A; c2 = -COEF_A; c3 = '0;      end
            3'd4:    begin c1 = -COEF_B; c2 =  COEF_C; c3 =  COEF_D; end
            3'd5:    begin c1 = -COEF_C; c2 =  COEF_B; c3 =  COEF_D; end
            3'd6:    begin c1 =  COEF_A; c2 =  COEF_A; c3 = '0;      end
            default: begin c1 = '0;      c2 = '0;      c3 = '0;      end
        endcase
        case (wheel)
            2'd0:    sel = c1;
            2'd1:    sel = c2;
            2'd2:    sel = c3;
            default: sel = '0;
        endcase
        return sel;
    endfunction

endpackage

// File: sv/omni_wheel_drive_mixer.sv
// ----------------------------------------------------------------------------
// Omni wheel drive mixer
// Three-wheel omni drive inverse kinematics from a velocity request to
// forward and reverse PWM duties for each wheel.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; the square root is split over four
// stages of four digits each, and every other step has a stage of its own.
// A stall at the output holds only the stages that are full; bubbles close up.
// Reset clears every valid bit and loads breakaway_offset = 750 and
// duty_limit = 3000; no other register is reset and there is no clearing pass.
// ----------------------------------------------------------------------------
module omni_wheel_drive_mixer
    import owdm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // Velocity request.
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  logic signed [IN_W-1:0] vel_x,
    input  logic signed [IN_W-1:0] vel_y,
    input  logic signed [IN_W-1:0] turn_rate,

    // Duty result.
    output logic                  duty_valid,
    input  logic                  duty_ready,
    output logic [DUTY_W-1:0]     wheel1_fwd_duty,
    output logic [DUTY_W-1:0]     wheel1_rev_duty,
    output logic [DUTY_W-1:0]     wheel2_fwd_duty,
    output logic [DUTY_W-1:0]     wheel2_rev_duty,
    output logic [DUTY_W-1:0]     wheel3_fwd_duty,
    output logic [DUTY_W-1:0]     wheel3_rev_duty
);

    // Stage map. Stage 0 squares the inputs, stage 1 sums them and picks the
    // sector, stages 2 to 5 take the root, stage 6 multiplies by the wheel
    // coefficients, stage 7 adds the turn term, stage 8 truncates and adds the
    // breakaway offset, and stage 9 clamps and holds the result for the output.
    localparam int NUM_STAGES = 10;
    localparam int S_SQUARE   = 0;
    localparam int S_SECTOR   = 1;
    localparam int S_ROOT     = 2;
    localparam int S_MULT     = S_ROOT + ROOT_STAGES;
    localparam int S_TURN     = S_MULT + 1;
    localparam int S_DRIVE    = S_TURN + 1;
    localparam int S_CLAMP    = S_DRIVE + 1;

    // ------------------------------------------------------------------------
    // Configuration registers. Writes are to arrive only while the block is idle,
    // which binds the user and is not enforced; the datapath reads them directly.
    // ------------------------------------------------------------------------
    logic [OFFSET_W-1:0] breakaway_reg;
    logic [OFFSET_W-1:0] breakaway_next;
    logic [DUTY_W-1:0]   duty_limit_reg;
    logic [DUTY_W-1:0]   duty_limit_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        breakaway_next  = breakaway_reg;
        duty_limit_next = duty_limit_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BREAKAWAY:  breakaway_next  = cfg_data[OFFSET_W-1:0];
                CFG_DUTY_LIMIT: duty_limit_next = cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            breakaway_reg  <= BREAKAWAY_RST;
            duty_limit_reg <= DUTY_LIMIT_RST;
        end
        else
        begin
            breakaway_reg  <= breakaway_next;
            duty_limit_reg <= duty_limit_next;
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline flow control. A stage loads when it is empty or when the stage
    // after it moves on, so a stall at the output only holds full stages.
    // ------------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_ready;

    always_comb
    begin
        stage_ready[NUM_STAGES-1] = ~valid_reg[NUM_STAGES-1] | duty_ready;
        for (int s = NUM_STAGES - 2; s >= 0; s--)
        begin
            stage_ready[s] = ~valid_reg[s] | stage_ready[s+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (stage_ready[0])
        begin
            valid_next[0] = cmd_valid;
        end
        for (int s = 1; s < NUM_STAGES; s++)
        begin
            if (stage_ready[s])
            begin
                valid_next[s] = valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign cmd_ready  = stage_ready[0];
    assign duty_valid = valid_reg[NUM_STAGES-1];

    // ------------------------------------------------------------------------
    // Stage 0: squares and sign flags.
    // ------------------------------------------------------------------------
    logic [SQ_W-1:0]        xsq_reg;
    logic [SQ_W-1:0]        ysq_reg;
    logic                   x_neg_reg;
    logic                   x_zero_reg;
    logic                   y_neg_reg;
    logic                   y_zero_reg;
    logic signed [IN_W-1:0] turn0_reg;
    logic signed [2*IN_W-1:0] xsq_full;
    logic signed [2*IN_W-1:0] ysq_full;

    assign xsq_full = vel_x * vel_x;
    assign ysq_full = vel_y * vel_y;

    always_ff @(posedge clk)
    begin
        if (stage_ready[S_SQUARE])
        begin
            xsq_reg    <= xsq_full[SQ_W-1:0];
            ysq_reg    <= ysq_full[SQ_W-1:0];
            x_neg_reg  <= vel_x[IN_W-1];
            x_zero_reg <= (vel_x == '0);
            y_neg_reg  <= vel_y[IN_W-1];
            y_zero_reg <= (vel_y == '0);
            turn0_reg  <= turn_rate;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: radicand and sector. The sector boundary at 30 degrees off an
    // axis is the exact test 3*y^2 against x^2; a tie goes away from zero angle.
    // ------------------------------------------------------------------------
    logic [RAD_W-1:0]       rad_reg;
    logic [SECT_W-1:0]      sect1_reg;
    logic signed [IN_W-1:0] turn1_reg;
    logic [RAD_W-1:0]       rad_next;
    logic [SECT_W-1:0]      sect_next;
    logic [RAD_W-1:0]       y3;
    logic [RAD_W-1:0]       x2;
    logic [1:0]             kmag;

    always_comb
    begin
        y3       = {ysq_reg, 1'b0} + {1'b0, ysq_reg};
        x2       = {1'b0, xsq_reg};
        rad_next = {1'b0, xsq_reg} + {1'b0, ysq_reg};
        if (x_zero_reg && y_zero_reg)
        begin
            kmag = 2'd0;
        end
        else if (!x_neg_reg && !x_zero_reg)
        begin
            kmag = (y3 >= x2) ? 2'd1 : 2'd0;
        end
        else if (x_zero_reg)
        begin
            kmag = 2'd2;
        end
        else
        begin
            kmag = (y3 > x2) ? 2'd2 : 2'd3;
        end
        sect_next = y_neg_reg ? (SECT_ZERO - {1'b0, kmag}) : (SECT_ZERO + {1'b0, kmag});
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[S_SECTOR])
        begin
            rad_reg   <= rad_next;
            sect1_reg <= sect_next;
            turn1_reg <= turn0_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stages 2 to 5: integer square root, four digits per stage.
    // ------------------------------------------------------------------------
    root_state_t            root_reg  [ROOT_STAGES];
    root_state_t            root_comb [ROOT_STAGES];
    root_state_t            root_in   [ROOT_STAGES];
    logic [SECT_W-1:0]      sect_pipe [ROOT_STAGES];
    logic signed [IN_W-1:0] turn_pipe [ROOT_STAGES];

    genvar r;
    generate
        for (r = 0; r < ROOT_STAGES; r++)
        begin : g_root
            if (r == 0)
            begin : g_first
                assign root_in[r] = '{rad: rad_reg, rem: '0, root: '0};
            end
            else
            begin : g_next
                assign root_in[r] = root_reg[r-1];
            end

            owdm_root_stage u_root_stage (
                .state_in  (root_in[r]),
                .state_out (root_comb[r])
            );

            always_ff @(posedge clk)
            begin
                if (stage_ready[S_ROOT + r])
                begin
                    root_reg[r]  <= root_comb[r];
                    sect_pipe[r] <= (r == 0) ? sect1_reg : sect_pipe[(r == 0) ? 0 : r - 1];
                    turn_pipe[r] <= (r == 0) ? turn1_reg : turn_pipe[(r == 0) ? 0 : r - 1];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------------
    // Stage 6: magnitude times each wheel's coefficient. The coefficient sign
    // is carried apart so the later shift truncates toward zero.
    // ------------------------------------------------------------------------
    logic [PROD_W-1:0]      prod_reg     [WHEELS];
    logic [WHEELS-1:0]      coef_neg_reg;
    logic signed [IN_W-1:0] turn6_reg;
    logic [PROD_W-1:0]      prod_next    [WHEELS];
    logic [WHEELS-1:0]      coef_neg_next;

    always_comb
    begin
        logic signed [COEF_W-1:0] coef;
        logic [COEF_W-1:0]        coef_abs;
        for (int w = 0; w < WHEELS; w++)
        begin
            coef             = coef_of(sect_pipe[ROOT_STAGES-1], WHEEL_W'(w));
            coef_neg_next[w] = coef[COEF_W-1];
            coef_abs         = coef[COEF_W-1] ? COEF_W'(-coef) : COEF_W'(coef);
            prod_next[w]     = root_reg[ROOT_STAGES-1].root * coef_abs[COEF_MAG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[S_MULT])
        begin
            prod_reg     <= prod_next;
            coef_neg_reg <= coef_neg_next;
            turn6_reg    <= turn_pipe[ROOT_STAGES-1];
        end
    end

    // ------------------------------------------------------------------------
    // Stage 7: projection times 256 plus or minus turn_rate * 40.
    // ------------------------------------------------------------------------
    logic signed [SUM_W-1:0] sum_reg  [WHEELS];
    logic signed [SUM_W-1:0] sum_next [WHEELS];

    always_comb
    begin
        logic signed [SUM_W-1:0] turn_ext;
        logic signed [SUM_W-1:0] turn40;
        logic signed [SUM_W-1:0] proj;
        turn_ext = {{(SUM_W-IN_W){turn6_reg[IN_W-1]}}, turn6_reg};
        turn40   = (turn_ext <<< 5) + (turn_ext <<< 3);
        for (int w = 0; w < WHEELS; w++)
        begin
            proj = $signed({{(SUM_W-PROJ_W){1'b0}}, prod_reg[w][PROD_W-1:PROJ_SHIFT]});
            if (coef_neg_reg[w])
            begin
                proj = -proj;
            end
            sum_next[w] = TURN_NEG_MASK[w] ? ((proj <<< 8) - turn40)
                                           : ((proj <<< 8) + turn40);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[S_TURN])
        begin
            sum_reg <= sum_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 8: divide by 256 toward zero, add the breakaway offset to a
    // nonzero drive, and fold in the wheel inversion as a direction bit.
    // ------------------------------------------------------------------------
    logic [DUTY_W-1:0] mag_reg   [WHEELS];
    logic [WHEELS-1:0] dir_neg_reg;
    logic [DUTY_W-1:0] mag_next  [WHEELS];
    logic [WHEELS-1:0] dir_neg_next;

    always_comb
    begin
        logic [SUM_W-1:0]  sum_abs;
        logic [DUTY_W-1:0] quot;
        for (int w = 0; w < WHEELS; w++)
        begin
            sum_abs         = sum_reg[w][SUM_W-1] ? SUM_W'(-sum_reg[w]) : SUM_W'(sum_reg[w]);
            quot            = sum_abs[SUM_W-1:8];
            mag_next[w]     = (quot == '0) ? '0
                                           : quot + {{(DUTY_W-OFFSET_W){1'b0}}, breakaway_reg};
            dir_neg_next[w] = sum_reg[w][SUM_W-1] ^ INVERT_MASK[w];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[S_DRIVE])
        begin
            mag_reg     <= mag_next;
            dir_neg_reg <= dir_neg_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 9: clamp at duty_limit and split into forward and reverse duties.
    // This is the output register.
    // ------------------------------------------------------------------------
    logic [DUTY_W-1:0] fwd_reg  [WHEELS];
    logic [DUTY_W-1:0] rev_reg  [WHEELS];
    logic [DUTY_W-1:0] fwd_next [WHEELS];
    logic [DUTY_W-1:0] rev_next [WHEELS];

    always_comb
    begin
        logic [DUTY_W-1:0] capped;
        for (int w = 0; w < WHEELS; w++)
        begin
            capped      = (mag_reg[w] > duty_limit_reg) ? duty_limit_reg : mag_reg[w];
            fwd_next[w] = dir_neg_reg[w] ? '0 : capped;
            rev_next[w] = dir_neg_reg[w] ? capped : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[S_CLAMP])
        begin
            fwd_reg <= fwd_next;
            rev_reg <= rev_next;
        end
    end

    assign wheel1_fwd_duty = fwd_reg[0];
    assign wheel1_rev_duty = rev_reg[0];
    assign wheel2_fwd_duty = fwd_reg[1];
    assign wheel2_rev_duty = rev_reg[1];
    assign wheel3_fwd_duty = fwd_reg[2];
    assign wheel3_rev_duty = rev_reg[2];

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------

    // An accepted request always lands in the first stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> valid_reg[S_SQUARE])
        else $error("accepted request did not enter the pipeline");

    // A full stage that cannot move on keeps its request.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[S_DRIVE] && !stage_ready[S_CLAMP]) |=> valid_reg[S_DRIVE])
        else $error("stalled request lost before the output stage");

    // Only one side of each wheel's bridge is driven.
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        duty_valid |-> ((wheel1_fwd_duty == '0 || wheel1_rev_duty == '0)
                     && (wheel2_fwd_duty == '0 || wheel2_rev_duty == '0)
                     && (wheel3_fwd_duty == '0 || wheel3_rev_duty == '0)))
        else $error("both duties of one wheel are nonzero");

    // Every duty respects the saturation ceiling.
    a_duty_limit: assert property (@(posedge clk) disable iff (!rst_n)
        duty_valid |-> (wheel1_fwd_duty <= duty_limit_reg && wheel1_rev_duty <= duty_limit_reg
                     && wheel2_fwd_duty <= duty_limit_reg && wheel2_rev_duty <= duty_limit_reg
                     && wheel3_fwd_duty <= duty_limit_reg && wheel3_rev_duty <= duty_limit_reg))
        else $error("duty above duty_limit");

endmodule

// File: sv/owdm_root_stage.sv
// ----------------------------------------------------------------------------
// Omni wheel drive mixer root stage
// Resolves a few digits of the restoring integer square root.
// ----------------------------------------------------------------------------
module owdm_root_stage
    import owdm_pkg::*;
(
    input  root_state_t state_in,
    output root_state_t state_out
);

    always_comb
    begin
        root_state_t      st;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        st = state_in;
        for (int i = 0; i < ROOT_STEPS; i++)
        begin
            // Bring down the next two radicand bits and try the next root bit.
            rem_sh = {st.rem[REM_W-3:0], st.rad[RAD_W-1 -: 2]};
            st.rad = {st.rad[RAD_W-3:0], 2'b00};
            trial  = {{(REM_W-ROOT_W-2){1'b0}}, st.root, 2'b01};
            if (rem_sh >= trial)
            begin
                st.rem  = rem_sh - trial;
                st.root = {st.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                st.rem  = rem_sh;
                st.root = {st.root[ROOT_W-2:0], 1'b0};
            end
        end
        state_out = st;
    end

endmodule

// File: bench/omni_wheel_drive_mixer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Omni wheel drive mixer testbench
// Sends velocity requests and register writes through their handshakes and
// predicts the six wheel duties of every accepted request. Each returned duty
// set is checked field by field against the oldest prediction. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module omni_wheel_drive_mixer_tb;
    import owdm_pkg::*;

    // Fixed-point constants of the mixer: trig values and wheel axes in signed Q1.16.
    localparam longint Q16_ONE     = 65536;
    localparam longint Q16_HALF    = 32768;
    localparam longint Q16_SIN60   = 56756;
    localparam longint AXIS_LONG   = 56754;
    localparam longint AXIS_SHORT  = 32768;
    localparam longint WHEEL_GAIN  = 40;

    // The pipeline is ten stages deep; the tail wait is longer than a pass through it.
    localparam int TAIL_CYCLES    = 20;
    // No legal stretch without a handshake comes anywhere near this.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 100;

    typedef enum logic [1:0] {
        REQ_CMD,    // a velocity request
        REQ_CFG,    // a register write, issued only once the pipeline is empty
        REQ_DRAIN   // hold the sender until every outstanding result is back
    } req_kind_t;

    typedef struct {
        req_kind_t                 kind;
        logic signed [IN_W-1:0]    x;
        logic signed [IN_W-1:0]    y;
        logic signed [IN_W-1:0]    t;
        logic [CFG_IDX_W-1:0]      idx;
        logic [CFG_DATA_W-1:0]     data;
    } pending_req_t;

    // Index 0 is wheel 1 forward, index 5 is wheel 3 reverse.
    typedef logic [5:0][DUTY_W-1:0] duty_vec_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   cmd_valid;
    logic                   cmd_ready;
    logic signed [IN_W-1:0] vel_x;
    logic signed [IN_W-1:0] vel_y;
    logic signed [IN_W-1:0] turn_rate;
    logic                   duty_valid;
    logic                   duty_ready;
    logic [DUTY_W-1:0]      wheel1_fwd_duty;
    logic [DUTY_W-1:0]      wheel1_rev_duty;
    logic [DUTY_W-1:0]      wheel2_fwd_duty;
    logic [DUTY_W-1:0]      wheel2_rev_duty;
    logic [DUTY_W-1:0]      wheel3_fwd_duty;
    logic [DUTY_W-1:0]      wheel3_rev_duty;

    pending_req_t      cmd_backlog [$];
    duty_vec_t         expected_duties [$];
    int                in_flight;
    int                send_gap;
    bit                send_calm;
    int                recv_stall;
    bit                recv_calm;
    int                quiet_cycles;
    int                fail_count;
    logic [OFFSET_W-1:0] offset_shadow;
    logic [DUTY_W-1:0]   limit_shadow;

    omni_wheel_drive_mixer u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .vel_x           (vel_x),
        .vel_y           (vel_y),
        .turn_rate       (turn_rate),
        .duty_valid      (duty_valid),
        .duty_ready      (duty_ready),
        .wheel1_fwd_duty (wheel1_fwd_duty),
        .wheel1_rev_duty (wheel1_rev_duty),
        .wheel2_fwd_duty (wheel2_fwd_duty),
        .wheel2_rev_duty (wheel2_rev_duty),
        .wheel3_fwd_duty (wheel3_fwd_duty),
        .wheel3_rev_duty (wheel3_rev_duty)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Duty predictor.
    // ------------------------------------------------------------------------

    // Division by a power of two that rounds toward zero.
    function automatic longint shift_toward_zero(input longint v, input int sh);
        if (v < 0)
            return -((-v) >>> sh);
        return v >>> sh;
    endfunction

    // Floor of the square root, one result bit at a time from the top.
    function automatic longint root_floor(input longint v);
        longint r;
        longint cand;
        int     b;
        r = 0;
        for (b = ROOT_W - 1; b >= 0; b--)
        begin
            cand = r | (longint'(1) << b);
            if (cand * cand <= v)
                r = cand;
        end
        return r;
    endfunction

    function automatic logic [DUTY_W-1:0] clamp_duty(input longint v,
                                                     input logic [DUTY_W-1:0] lim);
        if (v <= 0)
            return '0;
        if (v > longint'(lim))
            return lim;
        return v[DUTY_W-1:0];
    endfunction

    function automatic duty_vec_t mix_wheels(input logic signed [IN_W-1:0] vx,
                                             input logic signed [IN_W-1:0] vy,
                                             input logic signed [IN_W-1:0] tr,
                                             input logic [OFFSET_W-1:0]    offset,
                                             input logic [DUTY_W-1:0]      limit);
        longint    x;
        longint    y;
        longint    t;
        longint    ay;
        longint    y3;
        longint    x2;
        longint    mag;
        longint    cs;
        longint    sn;
        longint    ax;
        longint    ayx;
        longint    proj;
        longint    drive;
        int        sector;
        int        w;
        duty_vec_t duties;
        x  = longint'(vx);
        y  = longint'(vy);
        t  = longint'(tr);
        ay = (y < 0) ? -y : y;
        y3 = 3 * ay * ay;
        x2 = x * x;
        mag = root_floor(x2 + y * y);

        // Nearest multiple of 60 degrees; a tie goes away from zero angle.
        if (x == 0 && y == 0)
            sector = 0;
        else if (x > 0)
            sector = (y3 >= x2) ? 1 : 0;
        else if (x == 0)
            sector = 2;
        else
            sector = (y3 > x2) ? 2 : 3;
        if (y < 0)
            sector = -sector;

        case (sector)
            -3:      begin cs = -Q16_ONE;  sn = 0;          end
            -2:      begin cs = -Q16_HALF; sn = -Q16_SIN60; end
            -1:      begin cs =  Q16_HALF; sn = -Q16_SIN60; end
            1:       begin cs =  Q16_HALF; sn =  Q16_SIN60; end
            2:       begin cs = -Q16_HALF; sn =  Q16_SIN60; end
            3:       begin cs = -Q16_ONE;  sn = 0;          end
            default: begin cs =  Q16_ONE;  sn = 0;          end
        endcase

        for (w = 0; w < WHEELS; w++)
        begin
            case (w)
                0:       begin ax = -AXIS_LONG; ayx = -AXIS_SHORT; end
                1:       begin ax = -AXIS_LONG; ayx =  AXIS_SHORT; end
                default: begin ax = 0;          ayx =  Q16_ONE;    end
            endcase
            proj  = shift_toward_zero(mag * (cs * ax + sn * ayx) * WHEEL_GAIN, 40);
            drive = shift_toward_zero(proj * 256 + ((w == 1) ? -t : t) * WHEEL_GAIN, 8);
            if (drive > 0)
                drive = drive + longint'(offset);
            else if (drive < 0)
                drive = drive - longint'(offset);
            if (w != 0)
                drive = -drive;
            duties[2 * w]     = clamp_duty(drive, limit);
            duties[2 * w + 1] = clamp_duty(-drive, limit);
        end
        return duties;
    endfunction

    function automatic string duty_name(input int i);
        case (i)
            0:       return "wheel1_fwd_duty";
            1:       return "wheel1_rev_duty";
            2:       return "wheel2_fwd_duty";
            3:       return "wheel2_rev_duty";
            4:       return "wheel3_fwd_duty";
            default: return "wheel3_rev_duty";
        endcase
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. It works through the backlog one entry at a time. A
    // request that is already on the bus is held until it is accepted; the
    // idle gap drawn at issue time only starts counting after that.
    // in_flight is tracked from the handshakes seen at this edge, so the
    // decision to issue a register write never depends on another process.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            vel_x     <= '0;
            vel_y     <= '0;
            turn_rate <= '0;
            cfg_valid <= 1'b0;
            cfg_index <= CFG_BREAKAWAY;
            cfg_data  <= '0;
            send_gap  <= 0;
            send_calm <= 1'b0;
            in_flight <= 0;
        end
        else
        begin : drive_requests
            int flight_now;
            flight_now = in_flight + int'(cmd_valid && cmd_ready)
                       - int'(duty_valid && duty_ready);
            in_flight <= flight_now;

            if ((cmd_valid && !cmd_ready) || (cfg_valid && !cfg_ready))
            begin
                // Still waiting for the block to take the current request.
            end
            else if (send_gap > 0)
            begin
                cmd_valid <= 1'b0;
                cfg_valid <= 1'b0;
                send_gap  <= send_gap - 1;
            end
            else if (cmd_backlog.size() == 0)
            begin
                cmd_valid <= 1'b0;
                cfg_valid <= 1'b0;
            end
            else
            begin
                case (cmd_backlog[0].kind)
                    REQ_CMD:
                    begin
                        cmd_valid <= 1'b1;
                        vel_x     <= cmd_backlog[0].x;
                        vel_y     <= cmd_backlog[0].y;
                        turn_rate <= cmd_backlog[0].t;
                        cfg_valid <= 1'b0;
                        void'(cmd_backlog.pop_front());
                        send_gap  <= pick_gap(send_calm);
                        // Switch between idling and back-to-back stretches.
                        if ($urandom_range(63) == 0)
                            send_calm <= !send_calm;
                    end
                    REQ_CFG:
                    begin
                        cmd_valid <= 1'b0;
                        // Every request causes one result, so once all are back
                        // the pipeline is empty and the write is safe.
                        if (flight_now == 0)
                        begin
                            cfg_valid <= 1'b1;
                            cfg_index <= cmd_backlog[0].idx;
                            cfg_data  <= cmd_backlog[0].data;
                            void'(cmd_backlog.pop_front());
                        end
                        else
                        begin
                            cfg_valid <= 1'b0;
                        end
                    end
                    default:
                    begin
                        cmd_valid <= 1'b0;
                        cfg_valid <= 1'b0;
                        if (flight_now == 0)
                            void'(cmd_backlog.pop_front());
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. Results are checked before the prediction of this edge
    // is queued, so a result that shows up with nothing pending is flagged.
    // The shadow registers follow the register writes the block accepts.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_ready    <= 1'b0;
            recv_stall    <= 0;
            recv_calm     <= 1'b0;
            offset_shadow <= BREAKAWAY_RST;
            limit_shadow  <= DUTY_LIMIT_RST;
        end
        else
        begin : observe_duties
            duty_vec_t seen;
            duty_vec_t want;
            int        i;
            if (duty_valid && duty_ready)
            begin
                seen = {wheel3_rev_duty, wheel3_fwd_duty, wheel2_rev_duty,
                        wheel2_fwd_duty, wheel1_rev_duty, wheel1_fwd_duty};
                if (expected_duties.size() == 0)
                begin
                    $error("duty result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_duties.pop_front();
                    for (i = 0; i < 6; i++)
                    begin
                        if (seen[i] !== want[i])
                        begin
                            $error("%s mismatch: expected %0d, actual %0d",
                                   duty_name(i), want[i], seen[i]);
                            fail_count++;
                        end
                    end
                end
            end

            if (cmd_valid && cmd_ready)
                expected_duties.push_back(mix_wheels(vel_x, vel_y, turn_rate,
                                                     offset_shadow, limit_shadow));

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BREAKAWAY:  offset_shadow <= cfg_data[OFFSET_W-1:0];
                    CFG_DUTY_LIMIT: limit_shadow  <= cfg_data[DUTY_W-1:0];
                    default:        ;
                endcase
            end

            // Back-pressure: after each accepted result the sink may stall.
            if (recv_stall > 0)
            begin
                duty_ready <= 1'b0;
                recv_stall <= recv_stall - 1;
            end
            else if (duty_valid && duty_ready)
            begin
                recv_stall <= pick_gap(recv_calm);
                duty_ready <= 1'b1;
                if ($urandom_range(63) == 0)
                    recv_calm <= !recv_calm;
            end
            else
            begin
                duty_ready <= 1'b1;
            end
        end
    end

    // The watchdog counts cycles without any handshake.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (cfg_valid && cfg_ready)
            || (duty_valid && duty_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    task automatic push_cmd(input int x, input int y, input int t);
        pending_req_t r;
        r.kind = REQ_CMD;
        r.x    = x[IN_W-1:0];
        r.y    = y[IN_W-1:0];
        r.t    = t[IN_W-1:0];
        r.idx  = CFG_BREAKAWAY;
        r.data = '0;
        cmd_backlog.push_back(r);
    endtask

    task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input int data);
        pending_req_t r;
        r.kind = REQ_CFG;
        r.x    = '0;
        r.y    = '0;
        r.t    = '0;
        r.idx  = idx;
        r.data = data[CFG_DATA_W-1:0];
        cmd_backlog.push_back(r);
    endtask

    task automatic push_drain();
        pending_req_t r;
        r.kind = REQ_DRAIN;
        r.x    = '0;
        r.y    = '0;
        r.t    = '0;
        r.idx  = CFG_BREAKAWAY;
        r.data = '0;
        cmd_backlog.push_back(r);
    endtask

    function automatic int pick_extreme();
        case ($urandom_range(5))
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            default: return 32767;
        endcase
    endfunction

    // One random request, drawn from a mix of shapes: full range, small
    // vectors, vectors on an axis, vectors next to a sector boundary and
    // field extremes.
    task automatic push_random_cmd();
        int kind;
        int a;
        int b;
        int x;
        int y;
        int t;
        kind = $urandom_range(99);
        t = $signed(16'($urandom_range(65535)));
        if (kind < 40)
        begin
            x = $signed(16'($urandom_range(65535)));
            y = $signed(16'($urandom_range(65535)));
        end
        else if (kind < 58)
        begin
            x = $urandom_range(600) - 300;
            y = $urandom_range(600) - 300;
            t = $urandom_range(2000) - 1000;
        end
        else if (kind < 72)
        begin
            // On an axis, the zero vector included.
            a = ($urandom_range(3) == 0) ? 0 : $signed(16'($urandom_range(65535)));
            x = $urandom_range(1) ? a : 0;
            y = (x == 0) ? a : 0;
        end
        else if (kind < 88)
        begin
            // Next to the 30 or 150 degree boundary, where x is sqrt(3) * y.
            a = $urandom_range(1, 18000);
            b = (a * 1732) / 1000 + $urandom_range(6) - 3;
            x = $urandom_range(1) ? -b : b;
            y = $urandom_range(1) ? -a : a;
        end
        else if (kind < 92)
        begin
            // Next to the 90 degree boundary.
            x = $urandom_range(2) - 1;
            y = $signed(16'($urandom_range(65535)));
        end
        else
        begin
            x = pick_extreme();
            y = pick_extreme();
            t = pick_extreme();
        end
        push_cmd(x, y, t);
    endtask

    initial
    begin : run_test
        int phase;
        int n;
        fail_count = 0;
        rst_n = 1'b0;

        // Directed requests under the reset register values.
        push_cmd(0, 0, 0);
        push_cmd(0, 0, 32767);               // zero vector: only the turn acts
        push_cmd(0, 0, -32768);
        push_cmd(32767, 0, 0);
        push_cmd(-32768, 0, 0);              // negative x axis, 180 degrees
        push_cmd(0, 32767, 0);               // straight up, 90 degrees
        push_cmd(0, -32768, 0);              // straight down, -90 degrees
        push_cmd(32767, 32767, 0);
        push_cmd(-32768, -32768, -32768);
        push_cmd(17320, 10000, 0);           // just past 30 degrees
        push_cmd(17321, 10000, 0);           // just short of 30 degrees
        push_cmd(-17320, 10000, 0);
        push_cmd(-17321, -10000, 0);
        push_cmd(1, 0, 0);
        push_cmd(0, 0, 1);
        push_cmd(0, 0, -1);
        push_cmd(-1, -1, 100);
        push_cmd(32767, -32768, 32767);
        // No breakaway offset and a ceiling that never clips.
        push_cfg(CFG_BREAKAWAY, 0);
        push_cfg(CFG_DUTY_LIMIT, 65535);
        push_cmd(32767, 0, 0);
        push_cmd(0, 0, -32768);
        push_cmd(-32768, 32767, -32768);
        // A zero ceiling forces every duty to zero.
        push_cfg(CFG_DUTY_LIMIT, 0);
        push_cfg(CFG_BREAKAWAY, 4095);
        push_cmd(12345, -321, 5000);

        // Random phases, each under a register setting of its own.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: begin push_cfg(CFG_DUTY_LIMIT, 65535); push_cfg(CFG_BREAKAWAY, 0); end
                1: begin push_cfg(CFG_BREAKAWAY, 4095); end
                2: begin
                       push_cfg(CFG_BREAKAWAY, $urandom_range(4095));
                       push_cfg(CFG_DUTY_LIMIT, $urandom_range(65535));
                   end
                3: begin
                       push_cfg(CFG_BREAKAWAY, BREAKAWAY_RST);
                       push_cfg(CFG_DUTY_LIMIT, DUTY_LIMIT_RST);
                   end
                4: begin push_cfg(CFG_DUTY_LIMIT, 0); push_cfg(CFG_BREAKAWAY, 4095); end
                5: begin
                       push_cfg(CFG_DUTY_LIMIT, $urandom_range(2000));
                       push_cfg(CFG_BREAKAWAY, $urandom_range(4095));
                   end
                6: begin
                       // Bits above the offset width are dropped by the block.
                       push_cfg(CFG_BREAKAWAY, $urandom_range(65535));
                       push_cfg(CFG_DUTY_LIMIT, 65535);
                   end
                default:
                   begin
                       push_cfg(CFG_BREAKAWAY, 0);
                       push_cfg(CFG_DUTY_LIMIT, 1);
                   end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Once, halfway through a phase, hold the sender until the
                // pipeline has run dry.
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    push_drain();
                push_random_cmd();
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Sampled on the falling edge, when the driver and the monitor have
        // settled everything they did at the rising edge.
        while (cmd_backlog.size() != 0 || cmd_valid || cfg_valid || in_flight != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_duties.size() != 0)
        begin
            $error("%0d duty results never arrived", expected_duties.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
